[src/wdsu_pkg.sv]
// Package of shared constants and operation codes for the decimal scaling unit.
`default_nettype none
package wdsu_pkg;
  localparam int unsigned OperandBitsDefault = 256;
  localparam int unsigned WordBits           = 64;
  localparam int unsigned PowerBits          = 6;
  localparam int unsigned FuncBits           = 3;
  localparam int unsigned CountBits          = 6;
  localparam int unsigned ReduceLimit        = 96;

  localparam logic [FuncBits-1:0] FuncAdd   = 3'd0;
  localparam logic [FuncBits-1:0] FuncMul   = 3'd1;
  localparam logic [FuncBits-1:0] FuncUp    = 3'd2;
  localparam logic [FuncBits-1:0] FuncDown  = 3'd3;
  localparam logic [FuncBits-1:0] FuncRed   = 3'd4;
endpackage
`default_nettype wire

[src/wide_integer_decimal_scaling_unit.sv]
// Top level of the wide integer decimal scaling unit.
//   channel | direction | handshake            | payload
//   in      | input     | in_valid_i/in_stall_o | func, a_word0..3, b_word0..3, power
//   out     | output    | out_valid_o/out_stall_i | r_word0..3, div_count
// Add and multiply process one operand bit per cycle in the core.
// Scale up multiplies by ten once per power step; scale down and reduce
// divide by ten repeatedly in the bit-serial divider.
// One item is in work at a time; the output register holds a stalled result
// while the core takes the next item, and a second finished result waits in
// the core, with input stalled, until the output register is free.
// Reset is asynchronous and clears all control state.
`default_nettype none
module wide_integer_decimal_scaling_unit #(
  parameter int unsigned OperandBits = wdsu_pkg::OperandBitsDefault
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [wdsu_pkg::FuncBits-1:0]     func_i,
  input  wire logic [wdsu_pkg::WordBits-1:0]     a_word0_i,
  input  wire logic [wdsu_pkg::WordBits-1:0]     a_word1_i,
  input  wire logic [wdsu_pkg::WordBits-1:0]     a_word2_i,
  input  wire logic [wdsu_pkg::WordBits-1:0]     a_word3_i,
  input  wire logic [wdsu_pkg::WordBits-1:0]     b_word0_i,
  input  wire logic [wdsu_pkg::WordBits-1:0]     b_word1_i,
  input  wire logic [wdsu_pkg::WordBits-1:0]     b_word2_i,
  input  wire logic [wdsu_pkg::WordBits-1:0]     b_word3_i,
  input  wire logic [wdsu_pkg::PowerBits-1:0]    power_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [wdsu_pkg::WordBits-1:0]          r_word0_o,
  output logic [wdsu_pkg::WordBits-1:0]          r_word1_o,
  output logic [wdsu_pkg::WordBits-1:0]          r_word2_o,
  output logic [wdsu_pkg::WordBits-1:0]          r_word3_o,
  output logic [wdsu_pkg::CountBits-1:0]         div_count_o
);
  import wdsu_pkg::*;

  localparam int unsigned IoBits = 4 * WordBits;

  logic                   busy_q;
  logic                   start;
  logic                   done;
  logic [IoBits-1:0]      a_io, b_io;
  logic [OperandBits-1:0] a_op, b_op, r_op;
  logic [IoBits-1:0]      r_io;
  logic [CountBits-1:0]   cnt;
  logic [IoBits-1:0]      res_q;
  logic [CountBits-1:0]   res_cnt_q;

  // Operands fitted to the configured width: truncate or zero-extend.
  assign a_io = {a_word3_i, a_word2_i, a_word1_i, a_word0_i};
  assign b_io = {b_word3_i, b_word2_i, b_word1_i, b_word0_i};
  if (OperandBits >= IoBits) begin : g_wide
    assign a_op = OperandBits'(a_io);
    assign b_op = OperandBits'(b_io);
    assign r_io = r_op[IoBits-1:0];
  end else begin : g_narrow
    assign a_op = a_io[OperandBits-1:0];
    assign b_op = b_io[OperandBits-1:0];
    assign r_io = IoBits'(r_op);
  end

  // Input stalls from acceptance until the result moves to the output register; a pending output blocks new starts
  // only once the core would need to hand over a second result.
  assign in_stall_o = busy_q;
  assign start      = in_valid_i && !in_stall_o;

  wdsu_core #(.OperandBits(OperandBits)) u_core (
    .clk_i, .rst_ni, .start_i(start), .func_i,
    .a_i(a_op), .b_i(b_op), .power_i,
    .done_o(done), .r_o(r_op), .count_o(cnt)
  );

  // Busy covers the core and a result that could not yet move to the output.
  logic held_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      held_q      <= 1'b0;
      out_valid_o <= 1'b0;
      res_q       <= '0;
      res_cnt_q   <= '0;
    end else begin
      if (start) busy_q <= 1'b1;
      if (done || held_q) begin
        if (!out_valid_o || !out_stall_i) begin
          out_valid_o <= 1'b1;
          res_q       <= r_io;
          res_cnt_q   <= cnt;
          held_q      <= 1'b0;
          busy_q      <= 1'b0;
        end else begin
          held_q <= 1'b1;
        end
      end else if (out_valid_o && !out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  assign r_word0_o   = res_q[WordBits-1:0];
  assign r_word1_o   = res_q[2*WordBits-1:WordBits];
  assign r_word2_o   = res_q[3*WordBits-1:2*WordBits];
  assign r_word3_o   = res_q[4*WordBits-1:3*WordBits];
  assign div_count_o = res_cnt_q;
endmodule
`default_nettype wire

[src/wdsu_core.sv]
// Bit-serial datapath: shift-add multiply, add, times ten and rounded divide by ten.
`default_nettype none
module wdsu_core #(
  parameter int unsigned OperandBits = wdsu_pkg::OperandBitsDefault
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  input  wire logic [wdsu_pkg::FuncBits-1:0]      func_i,
  input  wire logic [OperandBits-1:0]             a_i,
  input  wire logic [OperandBits-1:0]             b_i,
  input  wire logic [wdsu_pkg::PowerBits-1:0]     power_i,
  output logic                                    done_o,
  output logic [OperandBits-1:0]                  r_o,
  output logic [wdsu_pkg::CountBits-1:0]          count_o
);
  import wdsu_pkg::*;

  localparam int unsigned PosBits = $clog2(OperandBits + 1);

  typedef enum logic [2:0] {
    StIdle, StAdd, StMul, StUp, StDiv, StRound, StDone
  } state_e;

  state_e                  state_q;
  logic [FuncBits-1:0]     func_q;
  logic [OperandBits-1:0]  acc_q;   // result being built / shifted
  logic [OperandBits-1:0]  opa_q;   // serial operand or dividend
  logic [OperandBits-1:0]  opb_q;   // multiplicand, shifted left each step
  logic [PosBits-1:0]      pos_q;   // bit position counter
  logic [PowerBits-1:0]    steps_q; // decimal steps left
  logic [CountBits-1:0]    count_q;
  logic [3:0]              rem_q;
  logic                    carry_q;

  // One bit of a serial adder on the low ends of acc and opa.
  logic sum_bit, sum_carry;
  assign sum_bit   = acc_q[0] ^ opa_q[0] ^ carry_q;
  assign sum_carry = (acc_q[0] & opa_q[0]) | (acc_q[0] & carry_q) | (opa_q[0] & carry_q);

  // Restoring division by ten, one dividend bit per cycle from the top.
  logic [4:0] rem_sh;
  logic       q_bit;
  logic [3:0] rem_next;
  assign rem_sh   = {rem_q, opa_q[OperandBits-1]};
  assign q_bit    = (rem_sh >= 5'd10);
  assign rem_next = q_bit ? 4'(rem_sh - 5'd10) : rem_sh[3:0];

  // Reduce needs the top bits clear.
  logic high_nz;
  assign high_nz = |(acc_q >> ReduceLimit);

  logic last_pos;
  assign last_pos = (pos_q == PosBits'(OperandBits - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_o  <= 1'b0;
      func_q  <= '0;
      acc_q   <= '0;
      opa_q   <= '0;
      opb_q   <= '0;
      pos_q   <= '0;
      steps_q <= '0;
      count_q <= '0;
      rem_q   <= '0;
      carry_q <= 1'b0;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        StIdle: begin
          if (start_i) begin
            func_q  <= func_i;
            pos_q   <= '0;
            carry_q <= 1'b0;
            count_q <= '0;
            steps_q <= power_i;
            case (func_i)
              FuncAdd: begin
                acc_q <= a_i; opa_q <= b_i; state_q <= StAdd;
              end
              FuncMul: begin
                acc_q <= '0; opa_q <= a_i; opb_q <= b_i; state_q <= StMul;
              end
              FuncUp: begin
                acc_q <= a_i; state_q <= StUp;
              end
              FuncDown, FuncRed: begin
                acc_q <= a_i; state_q <= StRound;
              end
              default: begin
                acc_q <= '0; state_q <= StDone;
              end
            endcase
          end
        end
        // Serial add: acc rotates right, one sum bit enters at the top.
        StAdd: begin
          acc_q   <= {sum_bit, acc_q[OperandBits-1:1]};
          opa_q   <= opa_q >> 1;
          carry_q <= sum_carry;
          pos_q   <= pos_q + 1'b1;
          if (last_pos) state_q <= StDone;
        end
        // Shift-add multiply: one bit of a per cycle, b shifts up.
        StMul: begin
          if (opa_q[0]) acc_q <= acc_q + opb_q;
          opa_q <= opa_q >> 1;
          opb_q <= opb_q << 1;
          pos_q <= pos_q + 1'b1;
          if (last_pos) state_q <= StDone;
        end
        // Times ten as x*8 + x*2, one step per cycle.
        StUp: begin
          if (steps_q == '0) begin
            state_q <= StDone;
          end else begin
            acc_q   <= (acc_q << 3) + (acc_q << 1);
            steps_q <= steps_q - 1'b1;
          end
        end
        // Decide whether another division is due, then load the divider.
        StRound: begin
          if ((func_q == FuncDown && steps_q != '0) ||
              (func_q == FuncRed && high_nz)) begin
            opa_q   <= acc_q;
            acc_q   <= '0;
            rem_q   <= '0;
            pos_q   <= '0;
            state_q <= StDiv;
          end else begin
            state_q <= StDone;
          end
        end
        // One quotient bit per cycle; rounding applied at the last bit.
        StDiv: begin
          opa_q <= opa_q << 1;
          rem_q <= rem_next;
          pos_q <= pos_q + 1'b1;
          if (last_pos) begin
            if (rem_next > 4'd5 || (rem_next == 4'd5 && q_bit))
              acc_q <= {acc_q[OperandBits-2:0], q_bit} + 1'b1;
            else
              acc_q <= {acc_q[OperandBits-2:0], q_bit};
            if (func_q == FuncDown) steps_q <= steps_q - 1'b1;
            if (func_q == FuncRed && count_q != '1) count_q <= count_q + 1'b1;
            state_q <= StRound;
          end else begin
            acc_q <= {acc_q[OperandBits-2:0], q_bit};
          end
        end
        StDone: begin
          done_o  <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign r_o     = acc_q;
  assign count_o = count_q;
endmodule
`default_nettype wire

[src/wdsu_checker.sv]
// Port-level checker for the decimal scaling unit, bound to the top level.
`default_nettype none
module wdsu_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire logic [wdsu_pkg::WordBits-1:0] r_word0_o,
  input wire logic [wdsu_pkg::CountBits-1:0] div_count_o
);
  // An accepted item makes the unit stall input on the next cycle.
  a_stall_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o) else $error("no stall after accept");
  // A result cannot appear the cycle after an accept.
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |=> !out_valid_o)
    else $error("result too early");
  // A stalled result stays valid and stable.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(r_word0_o) && $stable(div_count_o))
    else $error("stalled result changed");
endmodule

bind wide_integer_decimal_scaling_unit wdsu_checker u_wdsu_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .r_word0_o, .div_count_o
);
`default_nettype wire
